[hdl/ppmd_pkg.sv]
// Shared types and constants for the PID position motor drive.
// Used by ppmd_regs, ppmd_ctrl, ppmd_datapath and the top level.
`default_nettype none

package ppmd_pkg;

   // Default width of the kept error integral
   localparam int INTEG_WIDTH_DEF = 24;

   // Field and register widths
   localparam int ANGLE_W  = 10;
   localparam int LIMIT_W  = 8;
   localparam int SAMPLE_W = 10;
   localparam int GAIN_W   = 16;
   localparam int AGAIN_W  = 13;
   localparam int OFFS_W   = 10;
   localparam int ERR_W    = 15;
   localparam int DERR_W   = 16;
   localparam int MOP_W    = GAIN_W + 1;   // signed gain operand of the multiplier
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_OFFSET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_THR   = 3'd5;

   // Register reset values
   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd128;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd128;

   typedef struct packed {
      logic [GAIN_W-1:0]         prop_gain;
      logic [GAIN_W-1:0]         deriv_gain;
      logic [GAIN_W-1:0]         integ_gain;
      logic signed [AGAIN_W-1:0] angle_gain;
      logic [OFFS_W-1:0]         zero_offset;
      logic [OFFS_W-1:0]         integ_threshold;
   } cfg_type;

   // Multiplier operand selection
   typedef enum logic [1:0] {
      MSEL_GOAL  = 2'd0,
      MSEL_PROP  = 2'd1,
      MSEL_DERIV = 2'd2,
      MSEL_INTEG = 2'd3
   } msel_type;

   // Drive accumulator operation
   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_SUB  = 2'd2,
      ACC_ADD  = 2'd3
   } acc_op_type;

   // Controller states
   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_MUL_GOAL = 8'b0000_0010,
      ST_ERROR    = 8'b0000_0100,
      ST_MUL_PROP = 8'b0000_1000,
      ST_MUL_DER  = 8'b0001_0000,
      ST_MUL_INT  = 8'b0010_0000,
      ST_SUM      = 8'b0100_0000,
      ST_OUT      = 8'b1000_0000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       mul_en;
      msel_type   msel;
      logic       calc_err;
      logic       upd_state;
      acc_op_type acc_op;
      logic       load_out;
   } cmd_type;

endpackage

`default_nettype wire

[hdl/ppmd_regs.sv]
// Configuration register file for the PID position motor drive.
// Depends on ppmd_pkg for widths, register indexes and cfg_type.
`default_nettype none

module ppmd_regs
   import ppmd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PROP_GAIN:   cfg_in.prop_gain       = csr_wdata;
            REG_DERIV_GAIN:  cfg_in.deriv_gain      = csr_wdata;
            REG_INTEG_GAIN:  cfg_in.integ_gain      = csr_wdata;
            REG_ANGLE_GAIN:  cfg_in.angle_gain      = $signed(csr_wdata[AGAIN_W-1:0]);
            REG_ZERO_OFFSET: cfg_in.zero_offset     = csr_wdata[OFFS_W-1:0];
            REG_INTEG_THR:   cfg_in.integ_threshold = csr_wdata[OFFS_W-1:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain       <= PROP_GAIN_RST;
         cfg_ff.deriv_gain      <= DERIV_GAIN_RST;
         cfg_ff.integ_gain      <= '0;
         cfg_ff.angle_gain      <= '0;
         cfg_ff.zero_offset     <= '0;
         cfg_ff.integ_threshold <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hdl/ppmd_ctrl.sv]
// Sequencing state machine for the PID position motor drive.
// Depends on ppmd_pkg for state_type and cmd_type; drives the datapath commands.
`default_nettype none

module ppmd_ctrl
   import ppmd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.msel     = MSEL_GOAL;
      cmd.acc_op   = ACC_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_MUL_GOAL;
            end
         end
         ST_MUL_GOAL: begin
            cmd.mul_en = 1'b1;
            cmd.msel   = MSEL_GOAL;
            state_in   = ST_ERROR;
         end
         ST_ERROR: begin
            cmd.calc_err = 1'b1;
            state_in     = ST_MUL_PROP;
         end
         ST_MUL_PROP: begin
            cmd.mul_en    = 1'b1;
            cmd.msel      = MSEL_PROP;
            cmd.upd_state = 1'b1;
            state_in      = ST_MUL_DER;
         end
         ST_MUL_DER: begin
            cmd.mul_en = 1'b1;
            cmd.msel   = MSEL_DERIV;
            cmd.acc_op = ACC_LOAD;
            state_in   = ST_MUL_INT;
         end
         ST_MUL_INT: begin
            cmd.mul_en = 1'b1;
            cmd.msel   = MSEL_INTEG;
            cmd.acc_op = ACC_SUB;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[hdl/ppmd_datapath.sv]
// Datapath of the PID position motor drive: one shared multiplier, error and
// integral state, drive accumulator and output clamp. Depends on ppmd_pkg.
`default_nettype none

module ppmd_datapath
   import ppmd_pkg::*;
#(
   parameter int INTEG_WIDTH = INTEG_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  cmd_type                         cmd,
   input  cfg_type                         cfg,
   input  wire logic signed [ANGLE_W-1:0]  req_target_angle,
   input  wire logic [LIMIT_W-1:0]         req_power_limit,
   input  wire logic [SAMPLE_W-1:0]        req_sensor_sample,
   output logic                            rsp_direction,
   output logic [LIMIT_W-1:0]              rsp_drive_power
);

   localparam int IW    = INTEG_WIDTH;
   localparam int PW    = MOP_W + IW;   // product width
   localparam int QW    = PW - 8;       // product after the Q8.8 scale
   localparam int ACC_W = IW + 11;

   localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

   // captured transaction
   logic signed [ANGLE_W-1:0] angle_ff;
   logic [LIMIT_W-1:0]        limit_ff;
   logic [SAMPLE_W-1:0]       sample_ff;

   // loop state
   logic signed [ERR_W-1:0]  last_error_ff;
   logic signed [IW-1:0]     integ_ff, integ_in;

   // working registers
   logic signed [ERR_W-1:0]  err_ff;
   logic signed [DERR_W-1:0] derr_ff;
   logic signed [PW-1:0]     prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     dir_ff, dir_in;
   logic [LIMIT_W-1:0]       power_ff, power_in;

   // multiplier operands
   logic signed [MOP_W-1:0]  mop_a;
   logic signed [IW-1:0]     mop_b;

   always_comb begin
      case (cmd.msel)
         MSEL_GOAL: begin
            mop_a = {{(MOP_W-AGAIN_W){cfg.angle_gain[AGAIN_W-1]}}, cfg.angle_gain};
            mop_b = {{(IW-ANGLE_W){angle_ff[ANGLE_W-1]}}, angle_ff};
         end
         MSEL_PROP: begin
            mop_a = {1'b0, cfg.prop_gain};
            mop_b = {{(IW-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         MSEL_DERIV: begin
            mop_a = {1'b0, cfg.deriv_gain};
            mop_b = {{(IW-DERR_W){derr_ff[DERR_W-1]}}, derr_ff};
         end
         MSEL_INTEG: begin
            mop_a = {1'b0, cfg.integ_gain};
            mop_b = integ_ff;
         end
         default: begin
            mop_a = '0;
            mop_b = '0;
         end
      endcase
   end

   // Q8.8 scale with truncation toward zero: bias negatives by 255 before the shift
   logic signed [PW-1:0] prod_adj;
   logic signed [QW-1:0] prod_q;
   logic signed [ACC_W-1:0] prod_ext;

   assign prod_adj = prod_ff + $signed({{(PW-8){1'b0}}, {8{prod_ff[PW-1]}}});
   assign prod_q   = prod_adj[PW-1:8];
   assign prod_ext = {{(ACC_W-QW){prod_q[QW-1]}}, prod_q};

   // error and its difference; the goal is known to fit the error width
   logic signed [DERR_W-1:0] err_w;
   logic signed [DERR_W-1:0] derr_w;

   assign err_w  = $signed({prod_q[ERR_W-1], prod_q[ERR_W-1:0]})
                 + $signed({{(DERR_W-OFFS_W){1'b0}}, cfg.zero_offset})
                 - $signed({{(DERR_W-SAMPLE_W){1'b0}}, sample_ff});
   assign derr_w = err_w - $signed({last_error_ff[ERR_W-1], last_error_ff});

   // integral: clear on large error, else add the error and saturate
   logic signed [IW:0]    integ_sum;
   logic [ERR_W-1:0]      abs_err;

   assign integ_sum = $signed({integ_ff[IW-1], integ_ff})
                    + $signed({{(IW+1-ERR_W){err_ff[ERR_W-1]}}, err_ff});
   assign abs_err   = err_ff[ERR_W-1] ? (~err_ff + 1'b1) : err_ff;

   always_comb begin
      if (abs_err > {{(ERR_W-OFFS_W){1'b0}}, cfg.integ_threshold}) begin
         integ_in = '0;
      end else if (integ_sum[IW] != integ_sum[IW-1]) begin
         integ_in = integ_sum[IW] ? IMIN : IMAX;
      end else begin
         integ_in = integ_sum[IW-1:0];
      end
   end

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   // clamp to +-limit and split into sign and magnitude
   logic signed [ACC_W-1:0] lim_pos;
   logic signed [ACC_W-1:0] lim_neg;
   logic [ACC_W-1:0]        acc_neg;

   assign lim_pos = $signed({{(ACC_W-LIMIT_W){1'b0}}, limit_ff});
   assign lim_neg = -lim_pos;
   assign acc_neg = ~acc_ff + 1'b1;

   always_comb begin
      if (acc_ff > lim_pos) begin
         dir_in   = (limit_ff != '0);
         power_in = limit_ff;
      end else if (acc_ff < lim_neg) begin
         dir_in   = 1'b0;
         power_in = limit_ff;
      end else if (acc_ff > 0) begin
         dir_in   = 1'b1;
         power_in = acc_ff[LIMIT_W-1:0];
      end else begin
         dir_in   = 1'b0;
         power_in = acc_neg[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         integ_ff      <= '0;
      end else if (cmd.upd_state) begin
         last_error_ff <= err_ff;
         integ_ff      <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         angle_ff  <= req_target_angle;
         limit_ff  <= req_power_limit;
         sample_ff <= req_sensor_sample;
      end
      if (cmd.mul_en) begin
         prod_ff <= mop_a * mop_b;
      end
      if (cmd.calc_err) begin
         err_ff  <= err_w[ERR_W-1:0];
         derr_ff <= derr_w;
      end
      acc_ff <= acc_in;
      if (cmd.load_out) begin
         dir_ff   <= dir_in;
         power_ff <= power_in;
      end
   end

   assign rsp_direction   = dir_ff;
   assign rsp_drive_power = power_ff;

endmodule

`default_nettype wire

[hdl/pid_position_motor_drive.sv]
// PID position motor drive. Each transaction carries a target angle, a power
// limit and one sensor sample, and yields one result: direction and drive
// magnitude. After acceptance it steps through MUL_GOAL, ERROR, MUL_PROP,
// MUL_DER, MUL_INT, SUM and OUT before the next can be accepted; the single
// 17 x INTEG_WIDTH multiplier forms the goal, proportional, derivative and
// integral products in turn. The result sits in an output register, so a new
// transaction may be accepted while it waits to be taken. The user writes
// registers through the csr_ port only while the block is idle; the block does
// not enforce this. Depends on ppmd_pkg, ppmd_regs, ppmd_ctrl, ppmd_datapath.
`default_nettype none

module pid_position_motor_drive
   import ppmd_pkg::*;
#(
   parameter int INTEG_WIDTH = INTEG_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [ANGLE_W-1:0] req_target_angle,
   input  wire logic [LIMIT_W-1:0]        req_power_limit,
   input  wire logic [SAMPLE_W-1:0]       req_sensor_sample,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_direction,
   output logic [LIMIT_W-1:0]             rsp_drive_power,
   input  wire logic                      csr_write,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_wdata
);

   cfg_type cfg;
   cmd_type cmd;

   ppmd_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ppmd_datapath #(
      .INTEG_WIDTH (INTEG_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_target_angle  (req_target_angle),
      .req_power_limit   (req_power_limit),
      .req_sensor_sample (req_sensor_sample),
      .rsp_direction     (rsp_direction),
      .rsp_drive_power   (rsp_drive_power)
   );

endmodule

`default_nettype wire
